@@ design/lerb_pkg.sv @@
// ----------------------------------------------------------------------------
// lerb_pkg
// Shared codes, character constants and the result record of the receive
// line editor.
// ----------------------------------------------------------------------------
package lerb_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // Request actions.
   localparam logic ACT_RX   = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Control characters.
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_DEL = 8'h7F;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic       last;
      logic [5:0] byte_count;
   } result_type;

endpackage

@@ design/lerb_if.sv @@
// ----------------------------------------------------------------------------
// lerb_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface lerb_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic       port;
   logic [7:0] rx_byte;

   modport source (output valid, action, port, rx_byte, input ready);
   modport sink   (input valid, action, port, rx_byte, output ready);
endinterface

interface lerb_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] char_out;
   logic       last;
   logic [5:0] byte_count;

   modport source (output valid, kind, char_out, last, byte_count, input ready);
   modport sink   (input valid, kind, char_out, last, byte_count, output ready);
endinterface

@@ design/line_edit_receive_buffer.sv @@
// ----------------------------------------------------------------------------
// line_edit_receive_buffer
// Multi-port receive line editor with per-port ring buffers of characters.
// ----------------------------------------------------------------------------
// An echo is presented in the cycle after its transaction. A read-line request
// loads the registered store read data, then presents one line byte per cycle
// through the output register while rsp_bus.ready stays high, then the end
// result. One received byte is taken per cycle while the output register can
// take it; a read request holds off new requests until it has produced its end result.
// Reset clears indexes, line flags, state and output valid; the store is not.
module line_edit_receive_buffer #(
   parameter int FIFO_DEPTH = 64,
   parameter int PORT_COUNT = 2
) (
   input  logic              clock,
   input  logic              reset,
   lerb_req_if.sink          req_bus,
   lerb_rsp_if.source        rsp_bus
);

   // Ring index width and the width of the port select into the store.
   localparam int IDX_W = $clog2(FIFO_DEPTH);
   localparam int PW    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

   logic                 out_can;
   logic                 emit_valid;
   lerb_pkg::result_type emit;

   logic                 wr_en, rd_en;
   logic [PW-1:0]        wr_sel, rd_sel;
   logic [IDX_W-1:0]     wr_idx, rd_idx;
   logic [7:0]           wr_data, rd_data;

   // Output register: one result waits here until the sink takes it.
   logic                 out_valid_ff, out_valid_in;
   lerb_pkg::result_type out_ff;

   // The sequencer may hand over a new result when the register is empty or
   // its current transaction completes in this cycle.
   assign out_can = !out_valid_ff || rsp_bus.ready;

   lerb_seq #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .PORT_COUNT (PORT_COUNT),
      .IDX_W      (IDX_W),
      .PW         (PW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_action  (req_bus.action),
      .req_port    (req_bus.port),
      .req_rx_byte (req_bus.rx_byte),
      .out_can     (out_can),
      .emit_valid  (emit_valid),
      .emit        (emit),
      .wr_en       (wr_en),
      .wr_sel      (wr_sel),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_sel      (rd_sel),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data)
   );

   // The store holds the characters; its contents are only read at entries
   // that were written since the ring indexes last passed them.
   lerb_store #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .PORT_COUNT (PORT_COUNT),
      .IDX_W      (IDX_W),
      .PW         (PW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_sel  (wr_sel),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_sel  (rd_sel),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload is loaded only with a new result; no reset needed.
   always_ff @(posedge clock) begin
      if (emit_valid) begin
         out_ff <= emit;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.kind       = out_ff.kind;
   assign rsp_bus.char_out   = out_ff.char_out;
   assign rsp_bus.last       = out_ff.last;
   assign rsp_bus.byte_count = out_ff.byte_count;

endmodule

@@ design/lerb_store.sv @@
// ----------------------------------------------------------------------------
// lerb_store
// Character store: one ring of entries per port, one write and one read
// port, read data registered.
// ----------------------------------------------------------------------------
module lerb_store #(
   parameter int FIFO_DEPTH = 64,
   parameter int PORT_COUNT = 2,
   parameter int IDX_W      = 6,
   parameter int PW         = 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PW-1:0]    wr_sel,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [PW-1:0]    rd_sel,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [7:0]       rd_data
);

   logic [7:0] store_mem [PORT_COUNT][FIFO_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_sel][wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_sel][rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/lerb_seq.sv @@
// ----------------------------------------------------------------------------
// lerb_seq
// Sequencer: per-port ring indexes and line flags, editing of received
// bytes, and the line extraction walk through the character store.
// ----------------------------------------------------------------------------
module lerb_seq #(
   parameter int FIFO_DEPTH = 64,
   parameter int PORT_COUNT = 2,
   parameter int IDX_W      = 6,
   parameter int PW         = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic                   req_port,
   input  logic [7:0]             req_rx_byte,
   input  logic                   out_can,
   output logic                   emit_valid,
   output lerb_pkg::result_type   emit,
   output logic                   wr_en,
   output logic [PW-1:0]          wr_sel,
   output logic [IDX_W-1:0]       wr_idx,
   output logic [7:0]             wr_data,
   output logic                   rd_en,
   output logic [PW-1:0]          rd_sel,
   output logic [IDX_W-1:0]       rd_idx,
   input  logic [7:0]             rd_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_END  = 2'd2;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIFO_DEPTH - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] wr_idx_ff [PORT_COUNT];
   logic [IDX_W-1:0] wr_idx_in [PORT_COUNT];
   logic [IDX_W-1:0] rd_idx_ff [PORT_COUNT];
   logic [IDX_W-1:0] rd_idx_in [PORT_COUNT];
   logic [PORT_COUNT-1:0] lr_ff, lr_in;
   logic [PW-1:0]    sel_ff, sel_in;
   logic [5:0]       cnt_ff, cnt_in;

   logic             req_fire;
   logic             port_ok;
   logic [PW-1:0]    psel;
   logic [IDX_W-1:0] p_wr, p_rd, p_nxt, s_wr, s_rd, s_nxt;
   logic             is_bs;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
      idx_inc = (v == IDX_LAST) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] v);
      idx_dec = (v == '0) ? IDX_LAST : v - 1'b1;
   endfunction

   assign req_ready = (state_ff == ST_IDLE) && out_can;
   assign req_fire  = req_valid && req_ready;
   assign port_ok   = (32'(req_port) < PORT_COUNT);
   assign psel      = PW'(req_port);
   assign p_wr      = wr_idx_ff[psel];
   assign p_rd      = rd_idx_ff[psel];
   assign p_nxt     = idx_inc(p_wr);
   assign s_wr      = wr_idx_ff[sel_ff];
   assign s_rd      = rd_idx_ff[sel_ff];
   assign s_nxt     = idx_inc(s_rd);
   assign is_bs     = (req_rx_byte == lerb_pkg::CH_BS) || (req_rx_byte == lerb_pkg::CH_DEL);

   always_comb begin
      state_in   = state_ff;
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      lr_in      = lr_ff;
      sel_in     = sel_ff;
      cnt_in     = cnt_ff;
      emit_valid = 1'b0;
      emit       = '0;
      wr_en      = 1'b0;
      wr_sel     = psel;
      wr_idx     = p_wr;
      wr_data    = req_rx_byte;
      rd_en      = 1'b0;
      rd_sel     = psel;
      rd_idx     = p_rd;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && port_ok) begin
               if (req_action == lerb_pkg::ACT_RX) begin
                  if (req_rx_byte == lerb_pkg::CH_CR) begin
                     lr_in[psel] = 1'b1;
                  end
                  if (is_bs) begin
                     if (p_rd != p_wr) begin
                        wr_idx_in[psel] = idx_dec(p_wr);
                        emit_valid      = 1'b1;
                     end
                  end else begin
                     if (p_nxt != p_rd) begin
                        wr_en           = 1'b1;
                        wr_idx_in[psel] = p_nxt;
                     end
                     emit_valid = 1'b1;
                  end
                  emit.kind     = lerb_pkg::KIND_ECHO;
                  emit.char_out = req_rx_byte;
                  emit.last     = 1'b1;
               end else begin
                  emit.kind = lerb_pkg::KIND_END;
                  emit.last = 1'b1;
                  if (!lr_ff[psel]) begin
                     emit_valid = 1'b1;
                  end else if (p_rd == p_wr) begin
                     lr_in[psel] = 1'b0;
                     emit_valid  = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     sel_in   = psel;
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // rd_data holds the entry at the current read index of sel_ff.
            rd_sel = sel_ff;
            rd_idx = s_nxt;
            if (out_can) begin
               emit_valid        = 1'b1;
               rd_idx_in[sel_ff] = s_nxt;
               if (rd_data == lerb_pkg::CH_CR) begin
                  lr_in[sel_ff]   = 1'b0;
                  emit.kind       = lerb_pkg::KIND_END;
                  emit.last       = 1'b1;
                  emit.byte_count = cnt_ff;
                  state_in        = ST_IDLE;
               end else begin
                  emit.kind     = lerb_pkg::KIND_LINE;
                  emit.char_out = rd_data;
                  cnt_in        = cnt_ff + 6'd1;
                  if (s_nxt == s_wr) begin
                     state_in = ST_END;
                  end else begin
                     rd_en = 1'b1;
                  end
               end
            end
         end
         ST_END: begin
            if (out_can) begin
               lr_in[sel_ff]   = 1'b0;
               emit_valid      = 1'b1;
               emit.kind       = lerb_pkg::KIND_END;
               emit.last       = 1'b1;
               emit.byte_count = cnt_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lr_ff    <= '0;
         for (int i = 0; i < PORT_COUNT; i++) begin
            wr_idx_ff[i] <= '0;
            rd_idx_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         lr_ff     <= lr_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      cnt_ff <= cnt_in;
   end

`ifndef SYNTHESIS
   // A result is only produced when the output register can take it.
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> out_can)
      else $error("result produced while output register is occupied");

   // While scanning, the ring being read is never empty: its read index never equals the write index.
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (s_rd != s_wr))
      else $error("line scan reached an empty ring");

   // A result produced while idle always comes from an accepted request.
   a_idle_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && emit_valid) |-> req_fire)
      else $error("idle result without a request transaction");

   // The line flag of the scanned port is clear once a scan returns to idle.
   a_flag_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_in == ST_IDLE) |=> !lr_ff[$past(sel_ff)])
      else $error("line flag still set after line read");
`endif

endmodule

@@ sim/line_edit_checker.sv @@
// ----------------------------------------------------------------------------
// line_edit_checker
// Watches both channels of the receive line editor. It keeps its own copy of
// the per-port ring buffers to predict the echo, line-byte and end-of-line
// transactions, and checks every response against the oldest prediction.
// ----------------------------------------------------------------------------
module line_edit_checker (
   input  logic clock,
   input  logic reset,
   lerb_req_if  req_mon,
   lerb_rsp_if  rsp_mon,
   output int   error_count,
   output int   outstanding,
   output int   results_checked,
   output int   lines_read,
   output int   longest_line,
   output int   dropped_bytes
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PORTS = 2;
   localparam int DEPTH = 64;

   // Predicted image of the block: 6-bit indexes wrap modulo the depth.
   logic [7:0] line_store [PORTS][DEPTH];
   logic [5:0] wr_ptr [PORTS];
   logic [5:0] rd_ptr [PORTS];
   logic       line_flag [PORTS];

   lerb_pkg::result_type expected_q [$];
   int mismatches;
   int checked;
   int reads_done;
   int max_line;
   int drops;

   assign error_count     = mismatches;
   assign results_checked = checked;
   assign lines_read      = reads_done;
   assign longest_line    = max_line;
   assign dropped_bytes   = drops;

   function automatic void queue_result(input logic [1:0] kind, input logic [7:0] chr,
                                        input logic last, input logic [5:0] count);
      lerb_pkg::result_type r;
      r.kind       = kind;
      r.char_out   = chr;
      r.last       = last;
      r.byte_count = count;
      expected_q.push_back(r);
   endfunction

   // Works out the responses of one request and updates the buffer image.
   function automatic void apply_line_edit(input logic act, input logic prt,
                                           input logic [7:0] chr);
      logic [5:0] nxt;
      int         count;
      count = 0;
      if (act == lerb_pkg::ACT_RX) begin
         if (chr == lerb_pkg::CH_CR)
            line_flag[prt] = 1'b1;
         if (chr == lerb_pkg::CH_BS || chr == lerb_pkg::CH_DEL) begin
            // Erasing on an empty buffer produces nothing at all.
            if (rd_ptr[prt] == wr_ptr[prt])
               return;
            wr_ptr[prt] = wr_ptr[prt] - 6'd1;
         end else begin
            nxt = wr_ptr[prt] + 6'd1;
            if (nxt != rd_ptr[prt]) begin
               line_store[prt][wr_ptr[prt]] = chr;
               wr_ptr[prt] = nxt;
            end else begin
               drops++;
            end
         end
         queue_result(lerb_pkg::KIND_ECHO, chr, 1'b1, 6'd0);
      end else if (!line_flag[prt]) begin
         queue_result(lerb_pkg::KIND_END, 8'h00, 1'b1, 6'd0);
      end else begin
         while (rd_ptr[prt] != wr_ptr[prt] &&
                line_store[prt][rd_ptr[prt]] != lerb_pkg::CH_CR) begin
            queue_result(lerb_pkg::KIND_LINE, line_store[prt][rd_ptr[prt]], 1'b0, 6'd0);
            rd_ptr[prt] = rd_ptr[prt] + 6'd1;
            count++;
         end
         // The terminator, if one stopped the walk, is consumed as well.
         if (rd_ptr[prt] != wr_ptr[prt])
            rd_ptr[prt] = rd_ptr[prt] + 6'd1;
         line_flag[prt] = 1'b0;
         queue_result(lerb_pkg::KIND_END, 8'h00, 1'b1, 6'(count));
         reads_done++;
         if (count > max_line)
            max_line = count;
      end
   endfunction

   function automatic void compare_field(input string fname, input logic [7:0] want_val,
                                         input logic [7:0] got_val);
      if (got_val !== want_val) begin
         $display("%t: %s mismatch, expected %0h, actual %0h", $time, fname, want_val,
                  got_val);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      lerb_pkg::result_type want;
      if (reset) begin
         expected_q.delete();
         for (int p = 0; p < PORTS; p++) begin
            wr_ptr[p]    = '0;
            rd_ptr[p]    = '0;
            line_flag[p] = 1'b0;
         end
         mismatches = 0;
         checked    = 0;
         reads_done = 0;
         max_line   = 0;
         drops      = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            apply_line_edit(req_mon.action, req_mon.port, req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $display("%t: unexpected response, expected none, %s %0d %0h %0b %0d",
                        $time, "actual kind/char/last/count", rsp_mon.kind,
                        rsp_mon.char_out, rsp_mon.last, rsp_mon.byte_count);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               compare_field("kind", 8'(want.kind), 8'(rsp_mon.kind));
               compare_field("char_out", want.char_out, rsp_mon.char_out);
               compare_field("last", 8'(want.last), 8'(rsp_mon.last));
               compare_field("byte_count", 8'(want.byte_count), 8'(rsp_mon.byte_count));
               checked++;
            end
         end
      end
      outstanding = expected_q.size();
   end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives received characters and read-line requests into the two-port line
// editor with random gaps and response stalls; a checker beside the block
// predicts and compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_ITEMS = 480;
   // Settling time after the last expected response has arrived.
   localparam int DRAIN_CYCLES = 20;
   // Worst case is roughly 500 requests, each reading a full 63-byte line with
   // every response stalled as long as pick_gap allows; take several times that.
   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   logic clock;
   logic reset;

   lerb_req_if req_bus ();
   lerb_rsp_if rsp_bus ();

   int error_count;
   int outstanding;
   int results_checked;
   int lines_read;
   int longest_line;
   int dropped_bytes;

   int          items_sent;
   int          lines_sent;
   bit          calm;
   int unsigned cycle_count;

   line_edit_receive_buffer #(
      .FIFO_DEPTH (64),
      .PORT_COUNT (2)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   line_edit_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .error_count     (error_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .lines_read      (lines_read),
      .longest_line    (longest_line),
      .dropped_bytes   (dropped_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Alternates between quiet stretches, where neither side idles, and busy
   // stretches with random gaps and stalls. Updated on the rising edge so it
   // never changes in the same step in which the drivers read it.
   initial begin
      calm = 1'b0;
      forever begin
         repeat ($urandom_range(40, 300)) @(posedge clock);
         calm = ($urandom_range(0, 2) == 0);
      end
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Sends one request transaction. It is entered at a falling edge and
   // returns at the falling edge after the transaction was accepted, so valid
   // is assigned at most once per time step.
   task automatic send_item(input logic act, input logic prt, input logic [7:0] chr);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.port    <= prt;
      req_bus.rx_byte <= chr;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // A typed line: characters with the odd erase mixed in, a carriage return,
   // sometimes a character typed ahead of the read, and then the read request.
   // Long lines can run past the 63-byte capacity, so that bytes are dropped and a
   // carriage return may land on a full buffer.
   task automatic send_line(input logic prt, input int unsigned len);
      logic [7:0] chr;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            chr = $urandom_range(0, 1) ? lerb_pkg::CH_BS : lerb_pkg::CH_DEL;
         else if ($urandom_range(0, 4) == 0)
            chr = 8'($urandom_range(0, 255));
         else
            chr = 8'($urandom_range(32, 126));
         send_item(lerb_pkg::ACT_RX, prt, chr);
      end
      send_item(lerb_pkg::ACT_RX, prt, lerb_pkg::CH_CR);
      if ($urandom_range(0, 3) == 0)
         send_item(lerb_pkg::ACT_RX, prt, 8'($urandom_range(32, 126)));
      send_item(lerb_pkg::ACT_READ, prt, 8'($urandom_range(0, 255)));
      lines_sent++;
   endtask

   // The response side holds ready high, then may stall for a gap from pick_gap.
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   initial begin
      int unsigned sel;
      logic        prt;
      // Every input is known from time zero.
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.action  = lerb_pkg::ACT_RX;
      req_bus.port    = 1'b0;
      req_bus.rx_byte = 8'h00;
      items_sent      = 0;
      lines_sent      = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed part. Erasing on an empty buffer gives no response at all,
      // on either erase character and on either port.
      send_item(lerb_pkg::ACT_RX, 1'b0, lerb_pkg::CH_BS);
      send_item(lerb_pkg::ACT_RX, 1'b1, lerb_pkg::CH_DEL);
      // A read before any line was finished ends at once with a zero count.
      send_item(lerb_pkg::ACT_READ, 1'b0, 8'hFF);
      // The extremes of the character, then both erase characters removing
      // them again.
      send_item(lerb_pkg::ACT_RX, 1'b0, 8'h00);
      send_item(lerb_pkg::ACT_RX, 1'b0, 8'hFF);
      send_item(lerb_pkg::ACT_RX, 1'b0, lerb_pkg::CH_BS);
      send_item(lerb_pkg::ACT_RX, 1'b0, lerb_pkg::CH_DEL);
      // "A", carriage return, then "B" typed ahead. The read returns only "A"
      // and consumes the terminator; "B" stays behind for the next line.
      send_item(lerb_pkg::ACT_RX, 1'b0, 8'h41);
      send_item(lerb_pkg::ACT_RX, 1'b0, lerb_pkg::CH_CR);
      send_item(lerb_pkg::ACT_RX, 1'b0, 8'h42);
      send_item(lerb_pkg::ACT_READ, 1'b0, 8'h00);
      // The line flag is now clear again, so this read reports zero.
      send_item(lerb_pkg::ACT_READ, 1'b0, 8'h00);
      // Port 1: the carriage return is erased but the line stays ready, so
      // the read finds an empty buffer and ends with a zero count.
      send_item(lerb_pkg::ACT_RX, 1'b1, lerb_pkg::CH_CR);
      send_item(lerb_pkg::ACT_RX, 1'b1, lerb_pkg::CH_BS);
      send_item(lerb_pkg::ACT_READ, 1'b1, 8'h00);
      // Same again with characters after the erase: the read drains the
      // whole buffer because no terminator is left in it.
      send_item(lerb_pkg::ACT_RX, 1'b1, lerb_pkg::CH_CR);
      send_item(lerb_pkg::ACT_RX, 1'b1, lerb_pkg::CH_DEL);
      send_item(lerb_pkg::ACT_RX, 1'b1, 8'h55);
      send_item(lerb_pkg::ACT_RX, 1'b1, 8'hAA);
      send_item(lerb_pkg::ACT_RX, 1'b1, 8'h80);
      send_item(lerb_pkg::ACT_READ, 1'b1, 8'h5A);
      // Port 0 still holds "B"; finish that line and read it.
      send_item(lerb_pkg::ACT_RX, 1'b0, 8'h7E);
      send_item(lerb_pkg::ACT_RX, 1'b0, lerb_pkg::CH_CR);
      send_item(lerb_pkg::ACT_READ, 1'b0, 8'hA5);

      // Random part: mostly whole lines with random content on a random port,
      // the rest stray characters, stray reads and stray erases. Every eighth
      // line is long enough that it may fill the buffer.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         prt = 1'($urandom_range(0, 1));
         if (sel < 70) begin
            if (lines_sent % 8 == 7)
               send_line(prt, $urandom_range(56, 72));
            else
               send_line(prt, $urandom_range(0, 12));
         end else if (sel < 85) begin
            send_item(lerb_pkg::ACT_RX, prt, 8'($urandom_range(0, 255)));
         end else if (sel < 93) begin
            send_item(lerb_pkg::ACT_READ, prt, 8'($urandom_range(0, 255)));
         end else begin
            send_item(lerb_pkg::ACT_RX, prt,
                      $urandom_range(0, 1) ? lerb_pkg::CH_BS : lerb_pkg::CH_DEL);
         end
      end
      req_bus.valid <= 1'b0;

      // Let every predicted response arrive, then watch a little longer for
      // anything extra.
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Summary: %0d random requests after the directed set, %0d typed lines,",
               items_sent, lines_sent);
      $display("Summary: %0d responses checked, %0d ready line reads, longest %0d bytes, %s",
               results_checked, lines_read, longest_line,
               $sformatf("%0d bytes dropped on a full buffer.", dropped_bytes));
      if (error_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/lerb_pkg.sv
design/lerb_if.sv
design/lerb_store.sv
design/lerb_seq.sv
design/line_edit_receive_buffer.sv
sim/line_edit_checker.sv
sim/testbench.sv
